// File: hdl/kmsr_pkg.sv
// Shared types, constants and helpers of the key matrix scanner with repeat buffer.
package kmsr_pkg;

  localparam int KMSR_NUM_ROWS = 10;
  localparam int KMSR_ROW_W = 8;
  localparam int KMSR_SHIFT_ROW = 7;
  localparam int KMSR_SHIFT_BIT = 5;
  localparam int KMSR_HALF_W = 40;
  localparam int KMSR_IDX_W = 7;

  localparam int KMSR_BUF_DEPTH = 32;

  localparam int KMSR_CFG_IDX_W = 2;
  localparam int KMSR_CFG_DATA_W = 8;
  localparam logic [KMSR_CFG_IDX_W-1:0] KMSR_REG_DELAY = 2'd0;
  localparam logic [KMSR_CFG_IDX_W-1:0] KMSR_REG_INTERVAL = 2'd1;
  localparam logic [KMSR_CFG_DATA_W-1:0] KMSR_DELAY_RESET = 8'd12;
  localparam logic [KMSR_CFG_DATA_W-1:0] KMSR_INTERVAL_RESET = 8'd3;

  localparam logic KMSR_OP_SCAN = 1'b0;
  localparam logic KMSR_OP_READ = 1'b1;

  localparam int KMSR_OQ_DEPTH = 3;
  localparam int KMSR_OQ_PTR_W = $clog2(KMSR_OQ_DEPTH);
  localparam int KMSR_OQ_CNT_W = $clog2(KMSR_OQ_DEPTH + 1);

  typedef logic [KMSR_NUM_ROWS-1:0][KMSR_ROW_W-1:0] kmsr_rows_t;

  typedef struct packed {
    logic                  found;
    logic                  shift;
    logic [KMSR_IDX_W-1:0] idx;
  } kmsr_code_t;

  typedef struct packed {
    logic                  empty;
    logic                  found;
    logic                  shift;
    logic [KMSR_IDX_W-1:0] idx;
  } kmsr_result_t;

  typedef struct packed {
    logic         valid;
    kmsr_result_t data;
  } kmsr_push_t;

  typedef struct packed {
    logic                  changed;
    logic                  any;
    logic                  found;
    logic [KMSR_IDX_W-1:0] idx;
  } kmsr_scan_info_t;

  // Position of the highest set bit of a row byte.
  function automatic logic [2:0] kmsr_top_bit(input logic [KMSR_ROW_W-1:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int b = 0; b < KMSR_ROW_W; b++) begin
      if (v[b]) begin
        n = 3'(b);
      end
    end
    return n;
  endfunction

endpackage

// File: hdl/kmsr_in_if.sv
// Input channel: scan or read request items.
interface kmsr_in_if
  import kmsr_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [KMSR_HALF_W-1:0] scan_rows_low;
  logic [KMSR_HALF_W-1:0] scan_rows_high;

  modport source (output valid, output opcode, output scan_rows_low,
                  output scan_rows_high, input ready);
  modport sink (input valid, input opcode, input scan_rows_low,
                input scan_rows_high, output ready);
endinterface

// File: hdl/kmsr_out_if.sv
// Result channel: one item per read request.
interface kmsr_out_if
  import kmsr_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  buffer_empty;
  logic                  key_found;
  logic                  shift_held;
  logic [KMSR_IDX_W-1:0] key_index;

  modport source (output valid, output buffer_empty, output key_found,
                  output shift_held, output key_index, input ready);
  modport sink (input valid, input buffer_empty, input key_found,
                input shift_held, input key_index, output ready);
endinterface

// File: hdl/kmsr_cfg_if.sv
// Configuration write channel.
interface kmsr_cfg_if
  import kmsr_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [KMSR_CFG_IDX_W-1:0]  index;
  logic [KMSR_CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/kmsr_key_encode.sv
// Scan compare and fresh-key priority encoder.
module kmsr_key_encode
  import kmsr_pkg::*;
(
  input  kmsr_rows_t      rows_i,
  input  kmsr_rows_t      last_i,
  output kmsr_scan_info_t info_o
);

  logic [KMSR_ROW_W-1:0] fresh;

  always_comb begin
    info_o = '0;
    fresh = '0;
    info_o.changed = (rows_i != last_i);
    info_o.any = (rows_i != '0);
    // Walk from the top row down so the lowest row with a new key wins.
    for (int r = KMSR_NUM_ROWS - 1; r >= 0; r--) begin
      fresh = rows_i[r] & ~last_i[r];
      if (fresh != '0) begin
        info_o.found = 1'b1;
        info_o.idx = {4'(r), kmsr_top_bit(fresh)};
      end
    end
  end

endmodule

// File: hdl/kmsr_out_queue.sv
// Small result queue that drives the output channel.
module kmsr_out_queue
  import kmsr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  kmsr_push_t               push_i,
  output logic [KMSR_OQ_CNT_W-1:0] count_o,
  kmsr_out_if.source               out_ch
);

  kmsr_result_t q_r [KMSR_OQ_DEPTH];
  logic [KMSR_OQ_PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [KMSR_OQ_CNT_W-1:0] count_r, count_nxt;
  logic pop;

  function automatic logic [KMSR_OQ_PTR_W-1:0] step_ptr(input logic [KMSR_OQ_PTR_W-1:0] p);
    return (p == KMSR_OQ_PTR_W'(KMSR_OQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop = out_ch.valid && out_ch.ready;

  always_comb begin
    head_nxt = pop ? step_ptr(head_r) : head_r;
    tail_nxt = push_i.valid ? step_ptr(tail_r) : tail_r;
    count_nxt = count_r + KMSR_OQ_CNT_W'(push_i.valid) - KMSR_OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      count_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.valid) begin
      q_r[tail_r] <= push_i.data;
    end
  end

  assign count_o = count_r;
  assign out_ch.valid = (count_r != '0);
  assign out_ch.buffer_empty = q_r[head_r].empty;
  assign out_ch.key_found = q_r[head_r].found;
  assign out_ch.shift_held = q_r[head_r].shift;
  assign out_ch.key_index = q_r[head_r].idx;

endmodule

// File: hdl/key_matrix_scan_repeat_fifo.sv
// Top level of the key matrix scanner with typematic repeat and key buffer.
//
// The block takes one item per clock cycle on in_ch: either a full 10x8 key
// matrix scan or a read request. A scan that differs from the stored one is
// stored and pushes a key code (or a no-key code) into the key buffer; an
// unchanged scan with keys held drives the typematic repeat, which after
// repeat_delay+2 scans re-pushes the last code once every repeat_interval+1
// scans. The key buffer is a synchronous memory of BUF_DEPTH entries with a
// registered read and no overflow guard: after BUF_DEPTH pushes without
// reads the buffer reads as empty, and later pushes overwrite its oldest
// entries. Scans produce no result. Each read produces one transfer on
// out_ch, through the registered memory read and the output queue; a
// three-entry queue lets reads stream at one per cycle while out_ch accepts
// every cycle, and in_ch stalls only when that queue backs up. Register
// writes on cfg_ch are taken at once and must come while the block is idle.
module key_matrix_scan_repeat_fifo
  import kmsr_pkg::*;
#(
  parameter int BUF_DEPTH = KMSR_BUF_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  kmsr_in_if.sink    in_ch,
  kmsr_out_if.source out_ch,
  kmsr_cfg_if.sink   cfg_ch
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  // Repeat phases; the unused code behaves as the repeating phase.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DELAY = 2'd1;
  localparam logic [1:0] PH_REPEAT = 2'd2;

  // Configuration registers.
  logic [KMSR_CFG_DATA_W-1:0] delay_r, interval_r;

  // Scan and repeat state.
  kmsr_rows_t last_r, last_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] count_r, count_nxt;
  kmsr_code_t cur_r, cur_nxt;
  kmsr_code_t rep_r, rep_nxt;

  // Key buffer pointers and memory.
  logic [AW-1:0] rp_r, rp_nxt, wp_r, wp_nxt;
  kmsr_code_t mem [BUF_DEPTH];
  kmsr_code_t mem_rd_r;

  // Read pipeline stage between the memory and the output queue.
  logic s1_valid_r, s1_empty_r;

  kmsr_rows_t rows;
  kmsr_scan_info_t info;
  kmsr_push_t q_push;
  logic [KMSR_OQ_CNT_W-1:0] q_count;
  logic [KMSR_OQ_CNT_W:0] inflight;
  logic in_fire, scan_fire, read_fire, buf_empty, rd_en, push_en, shift_now;
  kmsr_code_t push_code;

  function automatic logic [AW-1:0] step_ptr(input logic [AW-1:0] p);
    return (p == AW'(BUF_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Configuration port: always ready, unknown indexes fall through.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= KMSR_DELAY_RESET;
      interval_r <= KMSR_INTERVAL_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        KMSR_REG_DELAY: delay_r <= cfg_ch.data;
        KMSR_REG_INTERVAL: interval_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input handshake. Everything that can still turn into a queue entry is
  // counted, so the queue always has room when the read stage lands.
  assign inflight = {1'b0, q_count} + (KMSR_OQ_CNT_W + 1)'(s1_valid_r);
  assign in_ch.ready = (inflight < (KMSR_OQ_CNT_W + 1)'(KMSR_OQ_DEPTH));
  assign in_fire = in_ch.valid && in_ch.ready;
  assign read_fire = in_fire && (in_ch.opcode == KMSR_OP_READ);
  assign scan_fire = in_fire && (in_ch.opcode == KMSR_OP_SCAN);

  assign rows = {in_ch.scan_rows_high, in_ch.scan_rows_low};

  kmsr_key_encode u_encode (
    .rows_i (rows),
    .last_i (last_r),
    .info_o (info)
  );

  assign shift_now = rows[KMSR_SHIFT_ROW][KMSR_SHIFT_BIT];

  // Scan and typematic repeat update.
  always_comb begin
    last_nxt = last_r;
    phase_nxt = phase_r;
    count_nxt = count_r;
    cur_nxt = cur_r;
    rep_nxt = rep_r;
    push_en = 1'b0;
    push_code = '0;
    if (scan_fire) begin
      if (info.changed) begin
        phase_nxt = PH_IDLE;
        last_nxt = rows;
        cur_nxt = '0;
        if (info.found) begin
          cur_nxt = '{found: 1'b1, shift: shift_now, idx: info.idx};
        end
        push_en = 1'b1;
        push_code = cur_nxt;
      end else if (!info.any) begin
        phase_nxt = PH_IDLE;
        rep_nxt = '0;
        cur_nxt = '0;
      end else begin
        case (phase_r)
          PH_IDLE: begin
            phase_nxt = PH_DELAY;
            count_nxt = delay_r;
            rep_nxt = cur_r;
            cur_nxt = '0;
          end
          PH_DELAY: begin
            if (count_r == '0) begin
              phase_nxt = PH_REPEAT;
            end else begin
              count_nxt = count_r - 1'b1;
            end
            cur_nxt = '0;
          end
          default: begin
            if (count_r == '0) begin
              cur_nxt = rep_r;
              push_en = 1'b1;
              push_code = rep_r;
              count_nxt = interval_r;
            end else begin
              count_nxt = count_r - 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Pointer update. A read and a push never share a cycle.
  assign buf_empty = (rp_r == wp_r);
  assign rd_en = read_fire && !buf_empty;

  always_comb begin
    rp_nxt = rd_en ? step_ptr(rp_r) : rp_r;
    wp_nxt = push_en ? step_ptr(wp_r) : wp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      phase_r <= PH_IDLE;
      count_r <= '0;
      cur_r <= '0;
      rep_r <= '0;
      rp_r <= '0;
      wp_r <= '0;
      s1_valid_r <= 1'b0;
      s1_empty_r <= 1'b0;
    end else begin
      last_r <= last_nxt;
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      cur_r <= cur_nxt;
      rep_r <= rep_nxt;
      rp_r <= rp_nxt;
      wp_r <= wp_nxt;
      s1_valid_r <= read_fire;
      s1_empty_r <= buf_empty;
    end
  end

  // Key buffer memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[wp_r] <= push_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_rd_r <= mem[rp_r];
    end
  end

  // An empty read reports zero in every other field.
  always_comb begin
    q_push = '0;
    q_push.valid = s1_valid_r;
    if (s1_empty_r) begin
      q_push.data.empty = 1'b1;
    end else begin
      q_push.data.found = mem_rd_r.found;
      q_push.data.shift = mem_rd_r.shift;
      q_push.data.idx = mem_rd_r.idx;
    end
  end

  kmsr_out_queue u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .count_o (q_count),
    .out_ch  (out_ch)
  );

  // The read stage may only land in a queue that has room.
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (q_count < KMSR_OQ_CNT_W'(KMSR_OQ_DEPTH)))
    else $error("read result arrives at a full output queue");

  // Every accepted read reaches the read stage in the next cycle.
  a_read_stage: assert property (@(posedge clk) disable iff (!rst_n)
    read_fire |=> s1_valid_r)
    else $error("accepted read did not reach the read stage");

  // A changed scan always pushes and moves the write pointer.
  a_push_on_change: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_fire && info.changed) |=> (wp_r != $past(wp_r)))
    else $error("changed scan did not advance the write pointer");

  // The read pointer moves only on a read of a non-empty buffer.
  a_rp_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (rp_r != $past(rp_r)) |-> $past(read_fire && !buf_empty))
    else $error("read pointer moved without a non-empty read");

endmodule

// File: tb/key_matrix_scan_repeat_fifo_tb.sv
// Self-checking testbench for the key matrix scanner with typematic repeat and key buffer.
`timescale 1ns / 100ps

module key_matrix_scan_repeat_fifo_tb;
  import kmsr_pkg::*;

  // Clock period is 12 ns, so each half period is 6 ns.
  localparam int CLK_HALF = 6;
  // Cycles to wait once the last expected read result has arrived. A scan that
  // makes no result may still be in flight, and this wait covers it.
  localparam int SETTLE_CYCLES = 8;
  // Cycles with no transfer on any channel before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;
  // Length of the long receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES = 400;
  localparam int MAT_W = 2 * KMSR_HALF_W;
  localparam int PTR_W = $clog2(KMSR_BUF_DEPTH);

  // Register indexes that the block has no register for; writes must be ignored.
  localparam logic [KMSR_CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [KMSR_CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {
    REP_IDLE  = 2'd0,
    REP_DELAY = 2'd1,
    REP_RUN   = 2'd2,
    REP_SPARE = 2'd3
  } repeat_phase_t;

  logic clk;
  logic rst_n;

  kmsr_in_if  in_ch ();
  kmsr_out_if out_ch ();
  kmsr_cfg_if cfg_ch ();

  key_matrix_scan_repeat_fifo dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // The scanner model. It mirrors the block's state and is advanced once for
  // every accepted input transfer, in acceptance order.
  logic [KMSR_CFG_DATA_W-1:0] delay_reg = KMSR_DELAY_RESET;
  logic [KMSR_CFG_DATA_W-1:0] interval_reg = KMSR_INTERVAL_RESET;
  kmsr_rows_t                 held_rows = '0;
  logic                       shift_flag = 1'b0;
  repeat_phase_t              rep_phase = REP_IDLE;
  logic [7:0]                 rep_count = '0;
  kmsr_code_t                 cur_code = '0;
  kmsr_code_t                 rep_code = '0;
  kmsr_code_t                 key_store [KMSR_BUF_DEPTH];
  logic [PTR_W-1:0]           store_rd = '0;
  logic [PTR_W-1:0]           store_wr = '0;

  // Read results that the block still owes, oldest first.
  kmsr_result_t pending_reads [$];

  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // Bumped by the stimulus to ask the receiver for a long hold-off.
  int hold_req = 0;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(KMSR_BUF_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // The buffer has no overflow guard: the write pointer simply moves on.
  task automatic store_code(input kmsr_code_t code);
    key_store[store_wr] = code;
    store_wr = next_ptr(store_wr);
  endtask

  task automatic predict_item(input logic op, input logic [MAT_W-1:0] mat);
    kmsr_rows_t            rows;
    kmsr_result_t          res;
    kmsr_code_t            code;
    logic [KMSR_ROW_W-1:0] fresh;
    int                    top;
    if (op == KMSR_OP_READ) begin
      // A read never touches the scan state; it pops one code or reports empty.
      res = '0;
      if (store_rd == store_wr) begin
        res.empty = 1'b1;
      end else begin
        code = key_store[store_rd];
        res.found = code.found;
        res.shift = code.shift;
        res.idx = code.idx;
        store_rd = next_ptr(store_rd);
      end
      pending_reads.push_back(res);
    end else begin
      rows = mat;
      if (rows == held_rows) begin
        // Unchanged scan: drive the typematic repeat.
        if (rows == '0) begin
          rep_phase = REP_IDLE;
          rep_code = '0;
          cur_code = '0;
        end else if (rep_phase == REP_IDLE) begin
          rep_phase = REP_DELAY;
          rep_count = delay_reg;
          rep_code = cur_code;
          cur_code = '0;
        end else if (rep_phase == REP_DELAY) begin
          if (rep_count == '0) begin
            rep_phase = REP_RUN;
          end else begin
            rep_count = rep_count - 1'b1;
          end
          cur_code = '0;
        end else begin
          // The spare phase behaves exactly like the running phase.
          if (rep_count == '0) begin
            cur_code = rep_code;
            store_code(cur_code);
            rep_count = interval_reg;
          end else begin
            rep_count = rep_count - 1'b1;
          end
        end
      end else begin
        // Changed scan: take shift, find the first newly pressed key, and push
        // its code, or the all-zero no-key code when nothing new went down.
        rep_phase = REP_IDLE;
        shift_flag = rows[KMSR_SHIFT_ROW][KMSR_SHIFT_BIT];
        cur_code = '0;
        for (int r = 0; r < KMSR_NUM_ROWS; r++) begin
          fresh = rows[r] & ~held_rows[r];
          if (fresh != '0 && !cur_code.found) begin
            top = 0;
            for (int b = 0; b < KMSR_ROW_W; b++) begin
              if (fresh[b]) begin
                top = b;
              end
            end
            cur_code.found = 1'b1;
            cur_code.shift = shift_flag;
            cur_code.idx = KMSR_IDX_W'(r * KMSR_ROW_W + top);
          end
        end
        held_rows = rows;
        store_code(cur_code);
      end
    end
  endtask

  // Offers one item and returns at the edge where it was transferred. Valid is
  // left high so that back-to-back items need only one assignment per edge.
  task automatic send_item(input logic op, input logic [MAT_W-1:0] mat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.scan_rows_low <= mat[KMSR_HALF_W-1:0];
    in_ch.scan_rows_high <= mat[MAT_W-1:KMSR_HALF_W];
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    predict_item(op, mat);
  endtask

  task automatic write_reg(input logic [KMSR_CFG_IDX_W-1:0] idx,
                           input logic [KMSR_CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
    if (idx == KMSR_REG_DELAY) begin
      delay_reg = data;
    end else if (idx == KMSR_REG_INTERVAL) begin
      interval_reg = data;
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering input and waits until the block has nothing left to say.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [MAT_W-1:0] rand_matrix();
    return MAT_W'({$urandom(), $urandom(), $urandom()});
  endfunction

  // Next scan of a plausible key sequence: mostly holds and single key
  // presses or releases, with some all-clear, all-down and noise scans.
  function automatic logic [MAT_W-1:0] next_matrix(input logic [MAT_W-1:0] cur);
    logic [MAT_W-1:0] m;
    int               k;
    int               b;
    m = cur;
    k = $urandom_range(99);
    if (k < 40) begin
      m = cur;
    end else if (k < 68) begin
      b = $urandom_range(MAT_W - 1);
      m[b] = ~m[b];
    end else if (k < 78) begin
      b = $urandom_range(MAT_W - 1);
      m[b] = ~m[b];
      b = $urandom_range(MAT_W - 1);
      m[b] = ~m[b];
    end else if (k < 87) begin
      m = '0;
    end else if (k < 96) begin
      m = rand_matrix();
    end else begin
      m = '1;
    end
    return m;
  endfunction

  // Reads on an empty buffer straight after reset, and an all-clear scan that
  // matches the reset scan and so pushes nothing.
  task automatic test_empty_after_reset();
    send_item(KMSR_OP_READ, '0);
    send_item(KMSR_OP_SCAN, '0);
    send_item(KMSR_OP_READ, '1);
  endtask

  // Corner keys: everything pressed (shift row included), release to the
  // no-key code, the last key, the first key, and the shift key alone.
  task automatic test_key_extremes();
    logic [MAT_W-1:0] m;
    send_item(KMSR_OP_SCAN, '1);
    send_item(KMSR_OP_SCAN, '0);
    m = '0;
    m[MAT_W-1] = 1'b1;
    send_item(KMSR_OP_SCAN, m);
    m[0] = 1'b1;
    send_item(KMSR_OP_SCAN, m);
    m = '0;
    m[KMSR_SHIFT_ROW * KMSR_ROW_W + KMSR_SHIFT_BIT] = 1'b1;
    send_item(KMSR_OP_SCAN, m);
    repeat (5) send_item(KMSR_OP_READ, rand_matrix());
  endtask

  // Shortest delay and interval: a held key repeats on every scan once the
  // delay phase has run out.
  task automatic test_fast_repeat();
    logic [MAT_W-1:0] m;
    settle();
    write_reg(KMSR_REG_DELAY, 8'd0);
    write_reg(KMSR_REG_INTERVAL, 8'd0);
    m = '0;
    m[3 * KMSR_ROW_W + 4] = 1'b1;
    repeat (5) send_item(KMSR_OP_SCAN, m);
    repeat (4) send_item(KMSR_OP_READ, '0);
  endtask

  // Longest delay and interval, with pushes that run the write pointer all the
  // way round onto the read pointer so the buffer reads as empty again.
  task automatic test_buffer_wrap();
    logic [MAT_W-1:0] m;
    settle();
    write_reg(KMSR_REG_DELAY, 8'hff);
    write_reg(KMSR_REG_INTERVAL, 8'hff);
    m = rand_matrix();
    for (int i = 0; i < KMSR_BUF_DEPTH; i++) begin
      m = ~m;
      send_item(KMSR_OP_SCAN, m);
    end
    send_item(KMSR_OP_READ, '0);
    m = ~m;
    send_item(KMSR_OP_SCAN, m);
    repeat (2) send_item(KMSR_OP_READ, '0);
    // A long hold under the longest delay never reaches the repeat phase.
    repeat (20) send_item(KMSR_OP_SCAN, m);
    send_item(KMSR_OP_READ, '0);
  endtask

  // Writes to indexes with no register behind them must change nothing.
  task automatic test_spare_indexes();
    settle();
    write_reg(REG_SPARE_A, 8'($urandom()));
    write_reg(REG_SPARE_B, 8'($urandom()));
    write_reg(REG_SPARE_A, 8'hff);
  endtask

  // One stretch of random key traffic under a given idling pattern, with a
  // fresh register setting, mostly small so that repeats are frequent.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_items);
    logic [MAT_W-1:0] m;
    int               k;
    settle();
    k = $urandom_range(9);
    if (k == 0) begin
      write_reg(KMSR_REG_DELAY, ($urandom_range(1) != 0) ? 8'hff : 8'h00);
      write_reg(KMSR_REG_INTERVAL, ($urandom_range(1) != 0) ? 8'hff : 8'h00);
    end else if (k == 1) begin
      write_reg(KMSR_REG_DELAY, 8'($urandom()));
      write_reg(KMSR_REG_INTERVAL, 8'($urandom()));
    end else begin
      write_reg(KMSR_REG_DELAY, 8'($urandom_range(6)));
      write_reg(KMSR_REG_INTERVAL, 8'($urandom_range(4)));
    end
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    m = held_rows;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 25) begin
        send_item(KMSR_OP_READ, rand_matrix());
      end else begin
        m = next_matrix(m);
        send_item(KMSR_OP_SCAN, m);
      end
    end
  endtask

  // The receiver holds off for a long stretch while reads keep coming, so the
  // output queue fills and the input channel has to stall.
  task automatic test_output_backpressure();
    logic [MAT_W-1:0] m;
    settle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    m = held_rows;
    for (int i = 0; i < 12; i++) begin
      m = rand_matrix();
      send_item(KMSR_OP_SCAN, m);
    end
    hold_req <= hold_req + 1;
    repeat (30) send_item(KMSR_OP_READ, rand_matrix());
  endtask

  initial begin : clock_gen
    clk = 1'b0;
    forever begin
      #CLK_HALF clk = ~clk;
    end
  end

  // Receiver: stalls out_ch at random or on request and checks every result
  // transfer against the oldest expected read result.
  initial begin : result_sink
    kmsr_result_t got;
    kmsr_result_t want;
    int           hold_left;
    int           hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.empty = out_ch.buffer_empty;
        got.found = out_ch.key_found;
        got.shift = out_ch.shift_held;
        got.idx = out_ch.key_index;
        if (pending_reads.size() == 0) begin
          $display("%0t: unexpected result transfer: got empty=%b found=%b shift=%b index=%0d",
                   $time, got.empty, got.found, got.shift, got.idx);
          error_count++;
        end else begin
          want = pending_reads.pop_front();
          if (got !== want) begin
            $display("%0t: read result mismatch: expected empty=%b found=%b shift=%b index=%0d",
                     $time, want.empty, want.found, want.shift, want.idx);
            $display("%0t:                       actual   empty=%b found=%b shift=%b index=%0d",
                     $time, got.empty, got.found, got.shift, got.idx);
            error_count++;
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transfer for %0d cycles, %0d read results outstanding",
             $time, QUIET_LIMIT, pending_reads.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= KMSR_OP_SCAN;
    in_ch.scan_rows_low <= '0;
    in_ch.scan_rows_high <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= KMSR_REG_DELAY;
    cfg_ch.data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part runs under the reset register values at first.
    test_empty_after_reset();
    test_key_extremes();
    test_fast_repeat();
    test_buffer_wrap();
    test_spare_indexes();

    // Random part, one stretch per idling pattern.
    test_random_traffic(0, 0, 140);
    test_random_traffic(83, 0, 140);
    test_random_traffic(0, 83, 140);
    test_random_traffic(6, 6, 140);
    test_output_backpressure();

    settle();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
